[design/lrsl_pkg.sv]
// Shared types, constants and a helper function for the linked radix sorter.
package lrsl_pkg;

   localparam int KEY_W       = 32;
   localparam int NIB_W       = 4;
   localparam int KEY_NIBBLES = 8;
   localparam int RADIX       = 10;
   localparam int DIG_W       = 4;
   localparam int BKT_W       = 4;

   localparam logic [NIB_W-1:0] DIGIT_MAX         = 4'd9;
   localparam logic [DIG_W-1:0] DIGIT_COUNT_RESET = 4'd8;
   localparam logic [BKT_W-1:0] LAST_BUCKET       = 4'd9;

   typedef enum logic [9:0] {
      ST_LOAD   = 10'b00_0000_0001,
      ST_TERM   = 10'b00_0000_0010,
      ST_HEAD   = 10'b00_0000_0100,
      ST_FIRST  = 10'b00_0000_1000,
      ST_DIST   = 10'b00_0001_0000,
      ST_COLL   = 10'b00_0010_0000,
      ST_CEND   = 10'b00_0100_0000,
      ST_EHEAD  = 10'b00_1000_0000,
      ST_EFIRST = 10'b01_0000_0000,
      ST_EMIT   = 10'b10_0000_0000
   } state_type;

   typedef struct packed {
      logic load;
      logic term;
      logic rd_head;
      logic follow;
      logic clr_bkt;
      logic distribute;
      logic coll;
      logic cend;
      logic emit;
      logic pass_clr;
      logic pass_inc;
   } cmd_type;

   typedef struct packed {
      logic last_acc;
      logic next_zero;
      logic coll_done;
      logic pass_last;
      logic digits_zero;
      logic out_room;
   } sts_type;

   // Bucket index of one key digit; nibbles above nine fall into bucket nine.
   function automatic logic [BKT_W-1:0] digit_of(input logic [KEY_W-1:0] key,
                                                 input logic [2:0]       pos);
      logic [NIB_W-1:0] d;
      d = key[pos*NIB_W +: NIB_W];
      return (d > DIGIT_MAX) ? DIGIT_MAX : d;
   endfunction

endpackage

[design/lsd_radix_sort_linked.sv]
// Top level of the linked-list decimal LSD radix sorter.
//
// Usage: requests arrive on the req_ channel (valid/ready), one record key in
// packed BCD per request. Each accepted request is stored while room remains;
// the request marked with req_last_in then starts the sort of the batch.
// While a batch is sorted and emitted, req_ready stays low.
// Results leave on the rsp_ channel in ascending stable order, one per stored
// record, with rsp_last_out on the final one and rsp_dropped set throughout
// when records beyond capacity were discarded in that batch.
// With n stored records and D digits in use, the sort writes the list end,
// then runs D passes (per pass: head read, first read, n distribution steps
// on the link store port, ten bucket collections and one tail write).
// Emission reads the list head and first record, then sends one record per
// cycle from the linked store, when the receiver does not stall.
// A stalled receiver holds the result register and the list walk pauses.
// The next batch may be loaded while the final result still waits.
// Reset is synchronous and active high: it empties the batch, clears the
// bucket pointers and sets the digit count to eight. The stores need no
// clearing pass, as only written entries are ever read.
module lsd_radix_sort_linked #(
   parameter int MAX_RECORDS = 64,
   parameter int MAX_DIGITS  = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_enable,
   input  logic [lrsl_pkg::DIG_W-1:0]  csr_digit_count,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [lrsl_pkg::KEY_W-1:0]  req_key_bcd,
   input  logic                        req_last_in,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [lrsl_pkg::KEY_W-1:0]  rsp_sorted_key,
   output logic                        rsp_last_out,
   output logic                        rsp_dropped
);
   import lrsl_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // The sequencer steps through load, per-digit distribute and collect
   // passes, and the final list walk.
   lrsl_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   // The datapath holds the key and link stores, the ten bucket lists and
   // the result register that separates the sorter from the receiver.
   lrsl_dpath #(
      .MAX_RECORDS (MAX_RECORDS),
      .MAX_DIGITS  (MAX_DIGITS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .csr_write_enable (csr_write_enable),
      .csr_digit_count  (csr_digit_count),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_key_bcd      (req_key_bcd),
      .req_last_in      (req_last_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sorted_key   (rsp_sorted_key),
      .rsp_last_out     (rsp_last_out),
      .rsp_dropped      (rsp_dropped)
   );

endmodule

[design/lrsl_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module lrsl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[design/lrsl_ctrl.sv]
// Sequencer for loading, distribution, collection and emission phases.
module lrsl_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  lrsl_pkg::sts_type sts,
   output lrsl_pkg::cmd_type cmd
);
   import lrsl_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_LOAD: begin
            cmd.load = 1'b1;
            if (sts.last_acc) state_in = ST_TERM;
         end
         ST_TERM: begin
            cmd.term     = 1'b1;
            cmd.pass_clr = 1'b1;
            state_in     = sts.digits_zero ? ST_EHEAD : ST_HEAD;
         end
         ST_HEAD: begin
            cmd.rd_head = 1'b1;
            state_in    = ST_FIRST;
         end
         ST_FIRST: begin
            cmd.follow  = 1'b1;
            cmd.clr_bkt = 1'b1;
            state_in    = ST_DIST;
         end
         ST_DIST: begin
            cmd.distribute = 1'b1;
            if (sts.next_zero) state_in = ST_COLL;
         end
         ST_COLL: begin
            cmd.coll = 1'b1;
            if (sts.coll_done) state_in = ST_CEND;
         end
         ST_CEND: begin
            cmd.cend     = 1'b1;
            cmd.pass_inc = 1'b1;
            state_in     = sts.pass_last ? ST_EHEAD : ST_HEAD;
         end
         ST_EHEAD: begin
            cmd.rd_head = 1'b1;
            state_in    = ST_EFIRST;
         end
         ST_EFIRST: begin
            cmd.follow = 1'b1;
            state_in   = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            if (sts.out_room && sts.next_zero) state_in = ST_LOAD;
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

endmodule

[design/lrsl_dpath.sv]
// Record stores, bucket pointers, counters and output register of the sorter.
module lrsl_dpath #(
   parameter int MAX_RECORDS = 64,
   parameter int MAX_DIGITS  = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  lrsl_pkg::cmd_type           cmd,
   output lrsl_pkg::sts_type           sts,
   input  logic                        csr_write_enable,
   input  logic [lrsl_pkg::DIG_W-1:0]  csr_digit_count,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [lrsl_pkg::KEY_W-1:0]  req_key_bcd,
   input  logic                        req_last_in,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [lrsl_pkg::KEY_W-1:0]  rsp_sorted_key,
   output logic                        rsp_last_out,
   output logic                        rsp_dropped
);
   import lrsl_pkg::*;

   localparam int LW        = $clog2(MAX_RECORDS + 1);
   localparam int KAW       = $clog2(MAX_RECORDS);
   localparam int DIG_LIMIT = (MAX_DIGITS < KEY_NIBBLES) ? MAX_DIGITS : KEY_NIBBLES;

   logic [DIG_W-1:0] digit_count_ff;
   logic [DIG_W-1:0] digits_eff;
   logic [DIG_W-1:0] pass_ff;
   logic [DIG_W-1:0] pass_next;
   logic [LW-1:0]    count_ff;
   logic             ovf_ff;
   logic [LW-1:0]    cur_p_ff;
   logic [LW-1:0]    end_ff;
   logic [BKT_W-1:0] j_ff;
   logic [LW-1:0]    head_ff [RADIX];
   logic [LW-1:0]    tail_ff [RADIX];

   logic             rsp_valid_ff;
   logic [KEY_W-1:0] rsp_key_ff;
   logic             rsp_last_ff;
   logic             rsp_drop_ff;

   logic             fire;
   logic             full;
   logic             out_room;
   logic             next_zero;
   logic             batch_done;
   logic [BKT_W-1:0] k;
   logic [LW-1:0]    head_k;
   logic [LW-1:0]    tail_k;
   logic [LW-1:0]    head_j;

   logic             link_we;
   logic [LW-1:0]    link_waddr;
   logic [LW-1:0]    link_wdata;
   logic             link_re;
   logic [LW-1:0]    link_raddr;
   logic [LW-1:0]    link_rdata;
   logic             key_re;
   logic [LW-1:0]    p_m1;
   logic [KEY_W-1:0] key_rdata;

   assign req_ready  = cmd.load;
   assign fire       = req_valid && cmd.load;
   assign full       = (count_ff == LW'(MAX_RECORDS));
   assign out_room   = !rsp_valid_ff || rsp_ready;
   assign next_zero  = (link_rdata == '0);
   assign batch_done = cmd.emit && out_room && next_zero;

   assign digits_eff = (digit_count_ff > DIG_W'(DIG_LIMIT)) ? DIG_W'(DIG_LIMIT)
                                                            : digit_count_ff;
   assign pass_next  = pass_ff + DIG_W'(1);

   assign k      = digit_of(key_rdata, pass_ff[2:0]);
   assign head_k = head_ff[k];
   assign tail_k = tail_ff[k];
   assign head_j = head_ff[j_ff];

   always_comb begin
      sts             = '0;
      sts.last_acc    = fire && req_last_in;
      sts.next_zero   = next_zero;
      sts.coll_done   = (j_ff == LAST_BUCKET);
      sts.pass_last   = (pass_next == digits_eff);
      sts.digits_zero = (digits_eff == '0);
      sts.out_room    = out_room;
   end

   // Link store write port: one writer per phase.
   always_comb begin
      link_we    = 1'b0;
      link_waddr = '0;
      link_wdata = '0;
      priority if (fire && !full) begin
         link_we    = 1'b1;
         link_waddr = count_ff;
         link_wdata = count_ff + LW'(1);
      end else if (cmd.term) begin
         link_we    = 1'b1;
         link_waddr = count_ff;
      end else if (cmd.distribute && head_k != '0) begin
         link_we    = 1'b1;
         link_waddr = tail_k;
         link_wdata = cur_p_ff;
      end else if (cmd.coll && head_j != '0) begin
         link_we    = 1'b1;
         link_waddr = end_ff;
         link_wdata = head_j;
      end else if (cmd.cend) begin
         link_we    = 1'b1;
         link_waddr = end_ff;
      end else begin
         link_we    = 1'b0;
      end
   end

   assign key_re     = cmd.follow || (cmd.distribute && !next_zero)
                    || (cmd.emit && out_room && !next_zero);
   assign link_re    = cmd.rd_head || key_re;
   assign link_raddr = cmd.rd_head ? '0 : link_rdata;
   assign p_m1       = link_rdata - LW'(1);

   lrsl_ram #(.WIDTH(LW), .DEPTH(MAX_RECORDS + 1)) u_link_ram (
      .clock (clock),
      .we    (link_we),
      .waddr (link_waddr),
      .wdata (link_wdata),
      .re    (link_re),
      .raddr (link_raddr),
      .rdata (link_rdata)
   );

   lrsl_ram #(.WIDTH(KEY_W), .DEPTH(MAX_RECORDS)) u_key_ram (
      .clock (clock),
      .we    (fire && !full),
      .waddr (count_ff[KAW-1:0]),
      .wdata (req_key_bcd),
      .re    (key_re),
      .raddr (p_m1[KAW-1:0]),
      .rdata (key_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_count_ff <= DIGIT_COUNT_RESET;
         count_ff       <= '0;
         ovf_ff         <= 1'b0;
         pass_ff        <= '0;
         j_ff           <= '0;
         rsp_valid_ff   <= 1'b0;
         for (int i = 0; i < RADIX; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
         end
      end else begin
         if (csr_write_enable) begin
            digit_count_ff <= csr_digit_count;
         end
         if (fire) begin
            if (!full) count_ff <= count_ff + LW'(1);
            else       ovf_ff   <= 1'b1;
         end else if (batch_done) begin
            count_ff <= '0;
            ovf_ff   <= 1'b0;
         end
         if (cmd.pass_clr) pass_ff <= '0;
         else if (cmd.pass_inc) pass_ff <= pass_next;
         if (cmd.rd_head) j_ff <= '0;
         else if (cmd.coll) j_ff <= j_ff + BKT_W'(1);
         if (cmd.clr_bkt) begin
            for (int i = 0; i < RADIX; i++) begin
               head_ff[i] <= '0;
               tail_ff[i] <= '0;
            end
         end else if (cmd.distribute) begin
            if (head_k == '0) head_ff[k] <= cur_p_ff;
            tail_ff[k] <= cur_p_ff;
         end
         if (cmd.emit && out_room) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (key_re) cur_p_ff <= link_rdata;
      if (cmd.rd_head) end_ff <= '0;
      else if (cmd.coll && head_j != '0) end_ff <= tail_ff[j_ff];
      if (cmd.emit && out_room) begin
         rsp_key_ff  <= key_rdata;
         rsp_last_ff <= next_zero;
         rsp_drop_ff <= ovf_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sorted_key = rsp_key_ff;
   assign rsp_last_out   = rsp_last_ff;
   assign rsp_dropped    = rsp_drop_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= LW'(MAX_RECORDS))
      else $error("record count beyond capacity");

   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> full)
      else $error("overflow flagged while store not full");

   a_link_rw: assert property (@(posedge clock) disable iff (reset)
      (cmd.distribute && link_we && link_re) |-> (link_waddr != link_raddr))
      else $error("link store read and write collide during distribution");

   a_emit_ptr: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit || cmd.distribute) |-> (cur_p_ff != '0))
      else $error("list walk on a null record pointer");

endmodule
